/* rtl/core/tce_pkg.sv */
package tce_pkg;

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 16;
    localparam int MODE_W  = 2;
    localparam int TCHAR_W = 9;
    localparam int TCOL_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int MAX_BYTES  = 9;
    localparam int CNT_W      = 4;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_ENCODE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_CHAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_BG    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_FG    = 2'd3;

    // encode modes
    localparam logic [MODE_W-1:0] MODE_LITERAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ESC_SYM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ESC_ALL = 2'd2;

    localparam logic [ATTR_W-1:0]  PREV_ATTR_RESET = 16'd6666;
    localparam logic [TCHAR_W-1:0] TRANS_CHAR_RESET = 9'h1FF;
    localparam logic [TCOL_W-1:0]  TRANS_COL_ANY    = 5'h1F;

    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_LO_V  = 8'h76;
    localparam logic [CHAR_W-1:0] CH_UP_V  = 8'h56;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef logic [CHAR_W-1:0] t_byte;
    typedef t_byte t_byte_arr [MAX_BYTES];

    function automatic t_byte hex_digit(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'd0, n};
        end
        return 8'h37 + {4'd0, n};
    endfunction

    // space, digits and letters pass through unescaped unless the mode escapes all
    function automatic logic is_plain(input t_byte c);
        return (c == 8'h20) || (c >= 8'h30 && c <= 8'h39) ||
               (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

/* rtl/core/tce_if.sv */
interface tce_cell_if import tce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              row_end;

    modport source (output valid, cell_char, cell_attr, row_end, input ready);
    modport sink   (input valid, cell_char, cell_attr, row_end, output ready);
endinterface

interface tce_byte_if import tce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

interface tce_cfg_if import tce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/text_cell_escape_encoder.sv */
// text cell escape encoder
//
// i_cell takes one console cell (character, attribute word, row end flag);
// o_byte gives the encoded text one byte per word, last_byte marking the
// final byte of a cell. i_cfg writes the mode and transparency registers by
// index and is always ready; write it only while no cell is in flight.
//
// a cell is encoded in the cycle it is accepted into a byte buffer (up to
// nine bytes); the buffer moves to the output serialiser, which sends one
// byte per cycle while o_byte is ready. the first byte is offered on o_byte
// once the cell has moved from the buffer into the serialiser. a cell has
// 1 to 9 bytes; cells producing no bytes are dropped at the buffer.
// the buffer accepts a new cell while the serialiser still holds bytes,
// so when o_byte stalls one more cell is taken, then i_cell.ready drops.
// reset (synchronous, active low) empties both stages, sets encode mode 1,
// disables transparency and sets the previous attribute to 6666.
module text_cell_escape_encoder
    import tce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tce_cfg_if.sink    i_cfg,
    tce_cell_if.sink   i_cell,
    tce_byte_if.source o_byte
);

    logic [MODE_W-1:0]  r_mode;
    logic [TCHAR_W-1:0] r_tchar;
    logic [TCOL_W-1:0]  r_tbg;
    logic [TCOL_W-1:0]  r_tfg;
    logic [ATTR_W-1:0]  r_prev_attr;

    logic              r_a_valid;
    t_byte_arr         r_a_bytes;
    logic [CNT_W-1:0]  r_a_cnt;

    logic              r_b_valid;
    t_byte_arr         r_b_bytes;
    logic [CNT_W-1:0]  r_b_cnt;
    logic [CNT_W-1:0]  r_b_idx;

    t_byte_arr         n_bytes;
    logic [CNT_W-1:0]  n_cnt;

    logic cfg_wr;
    logic in_acc;
    logic out_acc;
    logic b_last;
    logic b_done;
    logic b_free;
    logic a_move;

    assign cfg_wr  = i_cfg.valid && i_cfg.ready;
    assign in_acc  = i_cell.valid && i_cell.ready;
    assign out_acc = o_byte.valid && o_byte.ready;
    assign b_last  = (r_b_idx == r_b_cnt - 4'd1);
    assign b_done  = out_acc && b_last;
    assign b_free  = !r_b_valid || b_done;
    assign a_move  = r_a_valid && b_free;

    assign i_cfg.ready    = 1'b1;
    assign i_cell.ready   = !r_a_valid || b_free;
    assign o_byte.valid   = r_b_valid;
    assign o_byte.out_byte  = r_b_bytes[r_b_idx];
    assign o_byte.last_byte = b_last;

    // encode one cell into the byte buffer
    always_comb begin
        logic [3:0] fg;
        logic [3:0] bg;
        logic       tc_on;
        logic       fg_hit;
        logic       bg_hit;
        logic       transp;
        logic       escape;
        t_byte      ch;
        fg     = i_cell.cell_attr[3:0];
        bg     = i_cell.cell_attr[7:4];
        ch     = i_cell.cell_char;
        tc_on  = !r_tchar[TCHAR_W-1];
        fg_hit = (r_tfg == {1'b0, fg});
        bg_hit = (r_tbg == {1'b0, bg});
        transp = tc_on && (r_tchar[CHAR_W-1:0] == ch) &&
                 ((r_tfg == TRANS_COL_ANY) || fg_hit) &&
                 ((r_tbg == TRANS_COL_ANY) || bg_hit);
        escape = ((r_mode != MODE_LITERAL) || (ch == CH_BSL)) &&
                 (r_mode[1] || !is_plain(ch));
        for (int k = 0; k < MAX_BYTES; k++) begin
            n_bytes[k] = CH_NUL;
        end
        n_cnt = '0;
        if (i_cell.cell_attr != r_prev_attr) begin
            n_bytes[n_cnt] = CH_BSL;
            n_cnt = n_cnt + 4'd1;
            n_bytes[n_cnt] = (fg_hit && !tc_on) ? CH_LO_V : hex_digit(fg);
            n_cnt = n_cnt + 4'd1;
            n_bytes[n_cnt] = (bg_hit && !tc_on) ? CH_UP_V : hex_digit(bg);
            n_cnt = n_cnt + 4'd1;
        end
        if (transp) begin
            n_bytes[n_cnt] = CH_BSL;
            n_cnt = n_cnt + 4'd1;
            n_bytes[n_cnt] = CH_DASH;
            n_cnt = n_cnt + 4'd1;
        end else if (escape) begin
            n_bytes[n_cnt] = CH_BSL;
            n_cnt = n_cnt + 4'd1;
            n_bytes[n_cnt] = CH_G;
            n_cnt = n_cnt + 4'd1;
            n_bytes[n_cnt] = hex_digit(ch[7:4]);
            n_cnt = n_cnt + 4'd1;
            n_bytes[n_cnt] = hex_digit(ch[3:0]);
            n_cnt = n_cnt + 4'd1;
        end else if (ch != CH_NUL) begin
            n_bytes[n_cnt] = ch;
            n_cnt = n_cnt + 4'd1;
        end
        if (i_cell.row_end) begin
            n_bytes[n_cnt] = CH_BSL;
            n_cnt = n_cnt + 4'd1;
            n_bytes[n_cnt] = CH_N;
            n_cnt = n_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ESC_SYM;
            r_tchar     <= TRANS_CHAR_RESET;
            r_tbg       <= TRANS_COL_ANY;
            r_tfg       <= TRANS_COL_ANY;
            r_prev_attr <= PREV_ATTR_RESET;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg.index)
                    REG_ENCODE_MODE: r_mode  <= i_cfg.data[MODE_W-1:0];
                    REG_TRANS_CHAR:  r_tchar <= i_cfg.data[TCHAR_W-1:0];
                    REG_TRANS_BG:    r_tbg   <= i_cfg.data[TCOL_W-1:0];
                    REG_TRANS_FG:    r_tfg   <= i_cfg.data[TCOL_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_prev_attr <= i_cell.cell_attr;
            end
        end
    end

    // encode buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= (n_cnt != '0);
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
        if (in_acc) begin
            r_a_bytes <= n_bytes;
            r_a_cnt   <= n_cnt;
        end
    end

    // output serialiser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
            r_b_idx   <= '0;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else if (out_acc) begin
            r_b_idx   <= r_b_idx + 4'd1;
        end
        if (a_move) begin
            r_b_bytes <= r_a_bytes;
            r_b_cnt   <= r_a_cnt;
        end
    end

    a_b_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_cnt != '0) && (r_b_cnt <= 4'(MAX_BYTES)))
        else $error("serialiser holds an impossible byte count");

    a_b_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_idx < r_b_cnt))
        else $error("serialiser index ran past its byte count");

    a_a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_cnt != '0))
        else $error("encode buffer holds an empty cell");

    a_prev_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_prev_attr == $past(i_cell.cell_attr)))
        else $error("previous attribute not taken from accepted cell");

    a_stall_holds_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !o_byte.ready) |=> (r_b_valid && $stable(r_b_idx)))
        else $error("serialiser moved while output stalled");

endmodule
